>>> design/npc_pkg.sv
// Shared types and constants of the nearest palette color search.
package npc_pkg;

  localparam int unsigned IDX_W  = 8;
  localparam int unsigned COMP_W = 8;
  localparam int unsigned RGB_W  = 3 * COMP_W;
  localparam int unsigned SQ_W   = 2 * COMP_W;
  localparam int unsigned DIST_W = SQ_W + 2;

  // Above any real distance, so entry 0 always becomes the first best match.
  localparam logic [DIST_W-1:0] DIST_START = DIST_W'(256 * 256 + 256 * 256 + 256 * 256);

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_LOOKUP = 1'b1
  } npc_cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_DONE
  } npc_state_e;

  // Read issue towards the distance pipeline.
  typedef struct packed {
    logic             start;
    logic             valid;
    logic             last;
    logic [IDX_W-1:0] idx;
  } npc_rd_ctl_t;

  // Outcome of a finished scan.
  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] best_idx;
  } npc_status_t;

endpackage

>>> design/nearest_palette_color.sv
// Top level of the nearest palette color search.
//
// Input stream: tuser carries the command, tdata the entry index and the RGB
// color. A write request stores one palette entry in the accept cycle and
// gives no result; an index not below PALETTE_ENTRIES is dropped. A lookup
// request scans entries 0 to min(PALETTE_ENTRIES, 256) - 1 and returns the
// index of the entry with the smallest squared RGB distance, lowest index on
// a tie. All entries a lookup scans must be written first.
// Flow: a write keeps the input ready for the next request. A lookup reads
// one palette entry per cycle from the single read port of the palette RAM,
// and no new request is accepted until its result has moved to the output
// register.
// The output register holds a result until it is taken, and new requests are
// accepted meanwhile; a lookup that finishes while the previous result still
// waits holds its result until the output register frees up.
// Reset clears control state only; the palette contents are undefined until
// written.
module nearest_palette_color
  import npc_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // entry_index[7:0], red[15:8], green[23:16], blue[31:24]
  input  logic        s_axis_tuser,  // cmd[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata   // palette_index[7:0]
);

  localparam int unsigned ADDR_W   = $clog2(PALETTE_ENTRIES);
  localparam int unsigned SCAN_LEN = (PALETTE_ENTRIES < 256) ? PALETTE_ENTRIES : 256;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SCAN_LEN - 1);
  localparam logic [IDX_W+2:0] ENTRIES_W = (IDX_W + 3)'(PALETTE_ENTRIES);

  npc_state_e state_q, state_d;
  logic [IDX_W-1:0]  cnt_q, cnt_d;
  logic [COMP_W-1:0] qr_q, qg_q, qb_q;
  logic              load_query;
  logic              m_valid_q, m_valid_d;
  logic [IDX_W-1:0]  m_data_q, m_data_d;

  logic [IDX_W-1:0]  in_idx;
  logic [COMP_W-1:0] in_r, in_g, in_b;
  logic              in_accept;
  logic              wr_en;
  logic [IDX_W+ADDR_W-1:0] waddr_wide, raddr_wide;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [RGB_W-1:0]  rdata;

  npc_rd_ctl_t rd_ctl;
  npc_status_t status;

  assign in_idx = s_axis_tdata[7:0];
  assign in_r   = s_axis_tdata[15:8];
  assign in_g   = s_axis_tdata[23:16];
  assign in_b   = s_axis_tdata[31:24];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept     = s_axis_tvalid & s_axis_tready;

  assign wr_en      = in_accept && (npc_cmd_e'(s_axis_tuser) == CMD_WRITE)
                      && ({3'b000, in_idx} < ENTRIES_W);
  assign waddr_wide = {{ADDR_W{1'b0}}, in_idx};
  assign waddr      = waddr_wide[ADDR_W-1:0];
  assign raddr_wide = {{ADDR_W{1'b0}}, cnt_q};
  assign raddr      = raddr_wide[ADDR_W-1:0];

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    load_query   = 1'b0;
    m_valid_d    = m_valid_q;
    m_data_d     = m_data_q;
    rd_ctl.start = 1'b0;
    rd_ctl.valid = 1'b0;
    rd_ctl.last  = (cnt_q == LAST_IDX);
    rd_ctl.idx   = cnt_q;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_accept && (npc_cmd_e'(s_axis_tuser) == CMD_LOOKUP)) begin
          load_query   = 1'b1;
          rd_ctl.start = 1'b1;
          cnt_d        = '0;
          state_d      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_ctl.valid = 1'b1;
        if (rd_ctl.last) begin
          state_d = ST_WAIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_WAIT: begin
        if (status.done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold the result until the output register is free
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = status.best_idx;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    m_data_q <= m_data_d;
    if (load_query) begin
      qr_q <= in_r;
      qg_q <= in_g;
      qb_q <= in_b;
    end
  end

  npc_ram #(
    .WIDTH (RGB_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (waddr),
    .wdata_i ({in_b, in_g, in_r}),
    .re_i    (rd_ctl.valid),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  npc_dist u_dist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (rd_ctl),
    .query_r_i (qr_q),
    .query_g_i (qg_q),
    .query_b_i (qb_q),
    .rdata_i   (rdata),
    .status_o  (status)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  a_done_only_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.done |-> (state_q == ST_WAIT))
    else $error("scan finished outside the wait state");

  a_lookup_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (npc_cmd_e'(s_axis_tuser) == CMD_LOOKUP))
      |=> (state_q == ST_SCAN) && (cnt_q == '0))
    else $error("lookup did not start a scan at entry zero");

  a_no_write_during_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_ctl.valid |-> !wr_en)
    else $error("palette write overlaps a scan read");

  a_result_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.done |-> (status.best_idx <= LAST_IDX))
    else $error("best index beyond scanned entries");

endmodule

>>> design/npc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module npc_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/npc_dist.sv
// Distance pipeline: squares per component, sum, and running minimum.
module npc_dist
  import npc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  npc_rd_ctl_t       ctl_i,
  input  logic [COMP_W-1:0] query_r_i,
  input  logic [COMP_W-1:0] query_g_i,
  input  logic [COMP_W-1:0] query_b_i,
  input  logic [RGB_W-1:0]  rdata_i,
  output npc_status_t       status_o
);

  // stage 1: read data arrives from the RAM
  logic             v1_q, last1_q;
  logic [IDX_W-1:0] idx1_q;
  // stage 2: squared differences
  logic             v2_q, last2_q;
  logic [IDX_W-1:0] idx2_q;
  logic [SQ_W-1:0]  sq_r_q, sq_g_q, sq_b_q;
  logic [SQ_W-1:0]  sq_r_d, sq_g_d, sq_b_d;
  // running minimum
  logic [DIST_W-1:0] best_dist_q, best_dist_d;
  logic [IDX_W-1:0]  best_idx_q, best_idx_d;
  logic              done_q;
  logic [DIST_W-1:0] cand_dist;

  function automatic logic [SQ_W-1:0] sq_diff(logic [COMP_W-1:0] a, logic [COMP_W-1:0] b);
    logic [COMP_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

  assign sq_r_d = sq_diff(rdata_i[COMP_W-1:0], query_r_i);
  assign sq_g_d = sq_diff(rdata_i[2*COMP_W-1:COMP_W], query_g_i);
  assign sq_b_d = sq_diff(rdata_i[3*COMP_W-1:2*COMP_W], query_b_i);

  assign cand_dist = DIST_W'(sq_r_q) + DIST_W'(sq_g_q) + DIST_W'(sq_b_q);

  always_comb begin
    best_dist_d = best_dist_q;
    best_idx_d  = best_idx_q;
    if (ctl_i.start) begin
      best_dist_d = DIST_START;
      best_idx_d  = '0;
    end else if (v2_q && (cand_dist < best_dist_q)) begin
      // strict compare keeps the lowest index on a tie
      best_dist_d = cand_dist;
      best_idx_d  = idx2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      last1_q <= 1'b0;
      v2_q    <= 1'b0;
      last2_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      v1_q    <= ctl_i.valid;
      last1_q <= ctl_i.valid & ctl_i.last;
      v2_q    <= v1_q;
      last2_q <= v1_q & last1_q;
      done_q  <= v2_q & last2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q      <= ctl_i.idx;
    idx2_q      <= idx1_q;
    sq_r_q      <= sq_r_d;
    sq_g_q      <= sq_g_d;
    sq_b_q      <= sq_b_d;
    best_dist_q <= best_dist_d;
    best_idx_q  <= best_idx_d;
  end

  assign status_o.done     = done_q;
  assign status_o.best_idx = best_idx_q;

endmodule
